// ----- src/mono_framebuffer_draw_engine_macros.svh -----
// assertion helpers shared by the checker
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// consequent checked in the same cycle
`define MFDE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mfde_pkg.sv -----
package mfde_pkg;

    localparam int DEF_FRAME_WIDTH  = 128;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int STORE_DEPTH      = 1024;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH      = 2;
    localparam int CW               = 12;
    localparam int IN_W             = 64;
    localparam int OUT_W            = 16;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_PIXEL = 3'd1,
        CMD_HLINE = 3'd2,
        CMD_VLINE = 3'd3,
        CMD_RECT  = 3'd4,
        CMD_GLYPH = 3'd5,
        CMD_READ  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SEG,
        ST_PT,
        ST_WR,
        ST_RD,
        ST_RESULT
    } back_state_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic signed [8:0] px;
        logic signed [8:0] py;
        logic signed [8:0] ex;
        logic signed [8:0] ey;
        logic [4:0]        gidx;
        logic [ADDR_W-1:0] addr;
        logic              empty_rect;
    } q_entry_t;

    function automatic logic [4:0] glyph_index(input logic [7:0] code_in);
        logic [7:0] code;
        logic [4:0] idx;
        code = code_in;
        if (code >= 8'h61 && code <= 8'h7A)
            code = code - 8'h20;
        idx = 5'd0;
        if (code >= 8'h30 && code <= 8'h39)
            idx = 5'(code - 8'h30) + 5'd1;
        else
        begin
            case (code)
                8'h41:   idx = 5'd11;
                8'h43:   idx = 5'd12;
                8'h44:   idx = 5'd13;
                8'h45:   idx = 5'd14;
                8'h48:   idx = 5'd15;
                8'h49:   idx = 5'd16;
                8'h4C:   idx = 5'd17;
                8'h4D:   idx = 5'd18;
                8'h4E:   idx = 5'd19;
                8'h4F:   idx = 5'd20;
                8'h50:   idx = 5'd21;
                8'h52:   idx = 5'd22;
                8'h54:   idx = 5'd23;
                8'h55:   idx = 5'd24;
                8'h58:   idx = 5'd25;
                default: idx = 5'd0;
            endcase
        end
        return idx;
    endfunction

    function automatic logic [7:0] font_col(input logic [4:0] idx, input logic [2:0] cx);
        logic [39:0] row;
        logic [7:0]  col;
        case (idx)
            5'd1:    row = 40'h3E_45_49_51_3E;
            5'd2:    row = 40'h00_21_7F_01_00;
            5'd3:    row = 40'h23_45_49_51_21;
            5'd4:    row = 40'h22_41_49_49_36;
            5'd5:    row = 40'h18_28_48_7F_08;
            5'd6:    row = 40'h72_51_51_51_4E;
            5'd7:    row = 40'h1E_29_49_49_06;
            5'd8:    row = 40'h40_47_48_50_60;
            5'd9:    row = 40'h36_49_49_49_36;
            5'd10:   row = 40'h30_49_49_4A_3C;
            5'd11:   row = 40'h1F_24_44_24_1F;
            5'd12:   row = 40'h1C_22_41_41_22;
            5'd13:   row = 40'h7F_41_41_22_1C;
            5'd14:   row = 40'h7F_49_49_49_41;
            5'd15:   row = 40'h7F_08_08_08_7F;
            5'd16:   row = 40'h00_41_7F_41_00;
            5'd17:   row = 40'h7F_01_01_01_01;
            5'd18:   row = 40'h7F_20_10_20_7F;
            5'd19:   row = 40'h7F_10_08_04_7F;
            5'd20:   row = 40'h3E_41_41_41_3E;
            5'd21:   row = 40'h7F_48_48_48_30;
            5'd22:   row = 40'h7F_48_4C_4A_31;
            5'd23:   row = 40'h40_40_7F_40_40;
            5'd24:   row = 40'h7E_01_01_01_7E;
            5'd25:   row = 40'h63_14_08_14_63;
            default: row = 40'h0;
        endcase
        case (cx)
            3'd0:    col = row[39:32];
            3'd1:    col = row[31:24];
            3'd2:    col = row[23:16];
            3'd3:    col = row[15:8];
            3'd4:    col = row[7:0];
            default: col = 8'h00;
        endcase
        return col;
    endfunction

    function automatic logic signed [CW-1:0] clamp_to(input logic signed [CW-1:0] v,
                                                      input logic signed [CW-1:0] hi);
        logic signed [CW-1:0] r;
        r = v;
        if (v < 0)
            r = '0;
        else if (v > hi)
            r = hi;
        return r;
    endfunction

endpackage

// ----- src/mfde_front.sv -----
module mfde_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [mfde_pkg::IN_W-1:0] s_tdata,
    output logic                     q_valid,
    output mfde_pkg::q_entry_t       q_entry,
    input  logic                     q_pop
);

    localparam int PW = $clog2(mfde_pkg::QUEUE_DEPTH);

    mfde_pkg::q_entry_t q_mem_reg [mfde_pkg::QUEUE_DEPTH];
    mfde_pkg::q_entry_t in_entry;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          push;
    logic          pop;

    // decode and classify the incoming beat
    always_comb
    begin
        in_entry.cmd        = s_tdata[2:0];
        in_entry.px         = s_tdata[11:3];
        in_entry.py         = s_tdata[20:12];
        in_entry.ex         = s_tdata[29:21];
        in_entry.ey         = s_tdata[38:30];
        in_entry.gidx       = mfde_pkg::glyph_index(s_tdata[46:39]);
        in_entry.addr       = s_tdata[56:47];
        in_entry.empty_rect = ($signed(s_tdata[29:21]) <= 0) || ($signed(s_tdata[38:30]) <= 0);
    end

    assign s_tready = (count_reg != (PW+1)'(mfde_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= in_entry;
    end

endmodule

// ----- src/mfde_back.sv -----
module mfde_back #(
    parameter int FRAME_WIDTH  = mfde_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = mfde_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  mfde_pkg::q_entry_t        q_entry,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mfde_pkg::OUT_W-1:0] m_tdata
);

    localparam int CW        = mfde_pkg::CW;
    localparam int AW        = mfde_pkg::ADDR_W;
    localparam int ROW_BYTES = FRAME_WIDTH / 8;
    localparam logic signed [CW-1:0] W_S = CW'(FRAME_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(FRAME_HEIGHT);

    mfde_pkg::back_state_t state_reg, state_next;
    mfde_pkg::q_entry_t    cmd_reg, cmd_next;
    logic [1:0]            seg_reg, seg_next;
    logic                  horiz_reg, horiz_next;
    logic signed [CW-1:0]  fix_reg, fix_next;
    logic signed [CW-1:0]  cur_reg, cur_next;
    logic signed [CW-1:0]  end_reg, end_next;
    logic [2:0]            cx_reg, cx_next;
    logic [2:0]            cy_reg, cy_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  clr_cmd_reg, clr_cmd_next;
    logic [AW-1:0]         wa_reg, wa_next;
    logic [7:0]            mask_reg, mask_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_data_reg, out_data_next;
    logic [2:0]            out_cmd_reg, out_cmd_next;

    logic [7:0]    mem [mfde_pkg::STORE_DEPTH];
    logic [7:0]    rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;

    logic signed [CW-1:0] px_s, py_s, ex_s, ey_s, xr_s, yb_s;
    logic signed [CW-1:0] seg_fix, seg_a, seg_b, seg_lo, seg_hi, fix_lim, len_m1;
    logic                 seg_horiz, seg_last, fix_ok;
    logic signed [CW-1:0] pt_x, pt_y;
    logic [7:0]           glyph_col;
    logic                 pt_on, in_frame, plot_ok, adv;
    logic [15:0]          idx;

    assign px_s = CW'(cmd_reg.px);
    assign py_s = CW'(cmd_reg.py);
    assign ex_s = CW'(cmd_reg.ex);
    assign ey_s = CW'(cmd_reg.ey);
    assign xr_s = px_s + ex_s - CW'(1);
    assign yb_s = py_s + ey_s - CW'(1);

    // segment setup: hline, vline, or one of the four rectangle edges
    always_comb
    begin
        seg_horiz = 1'b1;
        seg_fix   = py_s;
        seg_a     = px_s;
        seg_b     = ex_s;
        seg_last  = 1'b1;
        if (cmd_reg.cmd == mfde_pkg::CMD_VLINE)
        begin
            seg_horiz = 1'b0;
            seg_fix   = px_s;
            seg_a     = py_s;
            seg_b     = ey_s;
        end
        else if (cmd_reg.cmd == mfde_pkg::CMD_RECT)
        begin
            seg_last = (seg_reg == 2'd3);
            case (seg_reg)
                2'd0:
                begin
                    seg_horiz = 1'b1; seg_fix = py_s; seg_a = px_s; seg_b = xr_s;
                end
                2'd1:
                begin
                    seg_horiz = 1'b1; seg_fix = yb_s; seg_a = px_s; seg_b = xr_s;
                end
                2'd2:
                begin
                    seg_horiz = 1'b0; seg_fix = px_s; seg_a = py_s; seg_b = yb_s;
                end
                default:
                begin
                    seg_horiz = 1'b0; seg_fix = xr_s; seg_a = py_s; seg_b = yb_s;
                end
            endcase
        end
        seg_lo  = (seg_a > seg_b) ? seg_b : seg_a;
        seg_hi  = (seg_a > seg_b) ? seg_a : seg_b;
        fix_lim = seg_horiz ? H_S : W_S;
        len_m1  = (seg_horiz ? W_S : H_S) - CW'(1);
        fix_ok  = (seg_fix >= 0) && (seg_fix < fix_lim);
    end

    // point under consideration
    always_comb
    begin
        glyph_col = mfde_pkg::font_col(cmd_reg.gidx, cx_reg);
        case (cmd_reg.cmd)
            mfde_pkg::CMD_PIXEL:
            begin
                pt_x  = px_s;
                pt_y  = py_s;
                pt_on = 1'b1;
            end
            mfde_pkg::CMD_GLYPH:
            begin
                pt_x  = px_s + CW'({1'b0, cx_reg});
                pt_y  = py_s + CW'({1'b0, cy_reg});
                pt_on = glyph_col[3'd6 - cy_reg];
            end
            default:
            begin
                pt_x  = horiz_reg ? cur_reg : fix_reg;
                pt_y  = horiz_reg ? fix_reg : cur_reg;
                pt_on = 1'b1;
            end
        endcase
        in_frame = (pt_x >= 0) && (pt_x < W_S) && (pt_y >= 0) && (pt_y < H_S);
        idx      = 16'(pt_y[7:0]) * 16'(ROW_BYTES) + 16'(pt_x[7:3]);
        plot_ok  = pt_on && in_frame && (idx < 16'(mfde_pkg::STORE_DEPTH));
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        seg_next       = seg_reg;
        horiz_next     = horiz_reg;
        fix_next       = fix_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_cmd_next   = clr_cmd_reg;
        wa_next        = wa_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_cmd_next   = out_cmd_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wa         = wa_reg;
        mem_ra         = cmd_reg.addr;
        mem_wd         = rdata_reg | mask_reg;
        adv            = 1'b0;

        case (state_reg)
            mfde_pkg::ST_CLR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                mem_wd       = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(mfde_pkg::STORE_DEPTH - 1))
                    state_next = clr_cmd_reg ? mfde_pkg::ST_RESULT : mfde_pkg::ST_IDLE;
            end
            mfde_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_entry;
                    seg_next     = 2'd0;
                    cx_next      = 3'd0;
                    cy_next      = 3'd0;
                    clr_cmd_next = 1'b1;
                    case (q_entry.cmd)
                        mfde_pkg::CMD_CLEAR: state_next = mfde_pkg::ST_CLR;
                        mfde_pkg::CMD_PIXEL,
                        mfde_pkg::CMD_GLYPH: state_next = mfde_pkg::ST_PT;
                        mfde_pkg::CMD_HLINE,
                        mfde_pkg::CMD_VLINE: state_next = mfde_pkg::ST_SEG;
                        mfde_pkg::CMD_RECT:
                            state_next = q_entry.empty_rect ? mfde_pkg::ST_RESULT
                                                            : mfde_pkg::ST_SEG;
                        mfde_pkg::CMD_READ:  state_next = mfde_pkg::ST_RD;
                        default:             state_next = mfde_pkg::ST_RESULT;
                    endcase
                end
            end
            mfde_pkg::ST_SEG:
            begin
                if (fix_ok)
                begin
                    horiz_next = seg_horiz;
                    fix_next   = seg_fix;
                    cur_next   = mfde_pkg::clamp_to(seg_lo, len_m1);
                    end_next   = mfde_pkg::clamp_to(seg_hi, len_m1);
                    state_next = mfde_pkg::ST_PT;
                end
                else if (seg_last)
                    state_next = mfde_pkg::ST_RESULT;
                else
                    seg_next = seg_reg + 2'd1;
            end
            mfde_pkg::ST_PT:
            begin
                if (plot_ok)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = idx[AW-1:0];
                    wa_next    = idx[AW-1:0];
                    mask_next  = 8'h80 >> pt_x[2:0];
                    state_next = mfde_pkg::ST_WR;
                end
                else
                    adv = 1'b1;
            end
            mfde_pkg::ST_WR:
            begin
                mem_we = 1'b1;
                adv    = 1'b1;
            end
            mfde_pkg::ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = mfde_pkg::ST_RESULT;
            end
            mfde_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = cmd_reg.cmd;
                    out_data_next  = (cmd_reg.cmd == mfde_pkg::CMD_READ) ? rdata_reg : 8'h00;
                    state_next     = mfde_pkg::ST_IDLE;
                end
            end
            default: state_next = mfde_pkg::ST_IDLE;
        endcase

        // step to the next point of the current command
        if (adv)
        begin
            case (cmd_reg.cmd)
                mfde_pkg::CMD_PIXEL: state_next = mfde_pkg::ST_RESULT;
                mfde_pkg::CMD_GLYPH:
                begin
                    state_next = mfde_pkg::ST_PT;
                    if (cy_reg == 3'd6)
                    begin
                        cy_next = 3'd0;
                        cx_next = cx_reg + 3'd1;
                        if (cx_reg == 3'd4)
                            state_next = mfde_pkg::ST_RESULT;
                    end
                    else
                        cy_next = cy_reg + 3'd1;
                end
                default:
                begin
                    if (cur_reg == end_reg)
                    begin
                        if (seg_last)
                            state_next = mfde_pkg::ST_RESULT;
                        else
                        begin
                            seg_next   = seg_reg + 2'd1;
                            state_next = mfde_pkg::ST_SEG;
                        end
                    end
                    else
                    begin
                        cur_next   = cur_reg + CW'(1);
                        state_next = mfde_pkg::ST_PT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfde_pkg::ST_CLR;
            clr_cnt_reg   <= '0;
            clr_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
            seg_reg       <= seg_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        horiz_reg    <= horiz_next;
        fix_reg      <= fix_next;
        cur_reg      <= cur_next;
        end_reg      <= end_next;
        wa_reg       <= wa_next;
        mask_reg     <= mask_next;
        out_data_reg <= out_data_next;
        out_cmd_reg  <= out_cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rdata_reg <= mem[mem_ra];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cmd_reg, out_data_reg};

endmodule

// ----- src/mono_framebuffer_draw_engine.sv -----
// 1-bit framebuffer drawing engine, 1024-byte store, MSB of a byte is the leftmost pixel.
// input stream s_*: one beat is one command (clear, pixel, hline, vline, rectangle,
//   glyph, read byte); output stream m_*: exactly one result beat per command, in order.
// a two-entry command queue separates the decoder from the drawing sequencer, so
//   s_tready stays high while the sequencer is busy until the queue fills.
// each command starts with the queue pop and ends by loading the result register:
//   a pixel or read touches one byte; a line or each rectangle edge is clipped first,
//   then its in-frame pixels are plotted; an empty rectangle goes straight to the result;
//   a glyph visits its 5x7 dots and plots the lit ones; clear writes one store byte per cycle.
// the store has one port; every plotted pixel is a read then an OR-write.
// a reset starts a clearing pass over all 1024 store bytes; beats are queued meanwhile
//   but none is executed until it ends.
// when m_tready is low the result is held in the output register; the sequencer
//   still finishes the next command and then waits for the register to free up.
module mono_framebuffer_draw_engine #(
    parameter int FRAME_WIDTH  = mfde_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = mfde_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // command, pos_x, pos_y, end_x, end_y, char_code, byte_addr, zero pad
    input  logic [mfde_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_data, done_command, zero pad
    output logic [mfde_pkg::OUT_W-1:0] m_tdata
);

    mfde_pkg::q_entry_t q_entry;
    logic               q_valid;
    logic               q_pop;

    mfde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    mfde_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- src/mfde_checker.sv -----
`include "mono_framebuffer_draw_engine_macros.svh"

module mfde_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mfde_pkg::OUT_W-1:0] m_tdata
);

    logic [7:0] out_data;
    logic       is_read;

    assign out_data = m_tdata[7:0];
    assign is_read  = (m_tdata[10:8] == mfde_pkg::CMD_READ);

    `MFDE_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "beat dropped")
    `MFDE_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "beat changed")
    `MFDE_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[15:11] == 5'b0, "pad bits set")
    `MFDE_ASSERT_SAME(a_read_only, clk, rst_n, m_tvalid && !is_read, out_data == 8'h00, "data set")
    `MFDE_ASSERT_SAME(a_ready_fall, clk, rst_n, $fell(s_tready), $past(s_tvalid && s_tready), "stall")

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);
